/* design/wbpe_pkg.sv */
package wbpe_pkg;

   localparam int CNT_W       = 5;
   localparam int COORD_W     = 16;
   localparam int T_W         = 16;
   localparam int U_W         = 32;
   localparam int QUEUE_DEPTH = 4;

   // one classified beat handed from front to back
   typedef struct packed {
      logic               is_eval;
      logic               wr_en;     // write inside the table
      logic               empty;     // path has no segments
      logic [CNT_W-1:0]   n;         // clamped segment count
      logic [3:0]         seg_w;
      logic [1:0]         pt;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [U_W-1:0]     u;
   } cmd_type;

endpackage

/* design/wbpe_queue.sv */
module wbpe_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  wbpe_pkg::cmd_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output wbpe_pkg::cmd_type pop_data
);

   localparam int PTR_W = $clog2(wbpe_pkg::QUEUE_DEPTH);

   wbpe_pkg::cmd_type slot_ff [0:wbpe_pkg::QUEUE_DEPTH-1];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]    cnt_ff, cnt_in;
   logic              push, pop;

   assign push_ready = (cnt_ff != (PTR_W+1)'(wbpe_pkg::QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/wbpe_front.sv */
module wbpe_front #(
   parameter int MAX_SEGMENTS = 16
) (
   input  logic                          mode,
   input  logic [3:0]                    segment_index,
   input  logic [1:0]                    point_index,
   input  logic [wbpe_pkg::COORD_W-1:0]  coord_x,
   input  logic [wbpe_pkg::COORD_W-1:0]  coord_y,
   input  logic [wbpe_pkg::COORD_W-1:0]  coord_z,
   input  logic [wbpe_pkg::U_W-1:0]      position_u,
   input  logic [wbpe_pkg::CNT_W-1:0]    segment_count,
   output wbpe_pkg::cmd_type             cmd
);

   logic [8:0] cnt_ext, seg_ext, max_ext;
   logic [wbpe_pkg::CNT_W-1:0] n_eff;

   always_comb begin
      cnt_ext = {4'b0, segment_count};
      seg_ext = {5'b0, segment_index};
      max_ext = 9'(MAX_SEGMENTS);
      // count above capacity acts as full capacity
      n_eff   = (cnt_ext > max_ext) ? wbpe_pkg::CNT_W'(MAX_SEGMENTS) : segment_count;

      cmd.is_eval = mode;
      cmd.wr_en   = !mode && (seg_ext < max_ext);
      cmd.empty   = (n_eff == '0);
      cmd.n       = n_eff;
      cmd.seg_w   = segment_index;
      cmd.pt      = point_index;
      cmd.x       = coord_x;
      cmd.y       = coord_y;
      cmd.z       = coord_z;
      cmd.u       = position_u;
   end

endmodule

/* design/wbpe_back.sv */
module wbpe_back #(
   parameter int MAX_SEGMENTS    = 16,
   parameter int PARAM_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  wbpe_pkg::cmd_type                   pop_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [wbpe_pkg::COORD_W-1:0] rsp_point_x,
   output logic signed [wbpe_pkg::COORD_W-1:0] rsp_point_y,
   output logic signed [wbpe_pkg::COORD_W-1:0] rsp_point_z,
   output logic                                rsp_path_empty
);

   localparam int IW   = wbpe_pkg::U_W - PARAM_FRAC_BITS;   // integer bits of u
   localparam int NS   = IW - 1;                            // one bit per wrap stage
   localparam int SEGW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CW   = wbpe_pkg::COORD_W;
   localparam int PW   = 3 * CW;                            // x,y,z of one point

   typedef struct packed {
      logic                       valid;
      logic                       is_eval;
      logic                       wr_en;
      logic                       empty;
      logic [wbpe_pkg::CNT_W-1:0] n;
      logic [wbpe_pkg::CNT_W-1:0] rem;
      logic [IW-1:0]              ibits;
      logic [wbpe_pkg::T_W-1:0]   t16;
      logic [3:0]                 seg_w;
      logic [1:0]                 pt;
      logic [PW-1:0]              pnt;
   } stage_type;

   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign pop_ready = advance;

   // ---------------- wrap: segment = floor(u) mod n, one bit per stage
   stage_type st_ff [0:NS];
   stage_type st_in [0:NS];
   logic [PARAM_FRAC_BITS+15:0] fext;

   always_comb begin
      fext            = {pop_data.u[PARAM_FRAC_BITS-1:0], 16'b0};
      st_in[0].valid   = pop_valid;
      st_in[0].is_eval = pop_data.is_eval;
      st_in[0].wr_en   = pop_data.wr_en;
      st_in[0].empty   = pop_data.empty;
      st_in[0].n       = pop_data.n;
      st_in[0].ibits   = pop_data.u[wbpe_pkg::U_W-1:PARAM_FRAC_BITS];
      // sign digit has weight -1
      st_in[0].rem     = pop_data.u[wbpe_pkg::U_W-1] ? pop_data.n - 1'b1 : '0;
      st_in[0].t16     = fext[PARAM_FRAC_BITS+15:PARAM_FRAC_BITS];
      st_in[0].seg_w   = pop_data.seg_w;
      st_in[0].pt      = pop_data.pt;
      st_in[0].pnt     = {pop_data.x, pop_data.y, pop_data.z};
   end

   for (genvar k = 0; k < NS; k++) begin : g_wrap
      logic [wbpe_pkg::CNT_W:0] two;
      always_comb begin
         st_in[k+1] = st_ff[k];
         two = {st_ff[k].rem, st_ff[k].ibits[IW-2-k]};
         if (two >= {1'b0, st_ff[k].n}) begin
            st_in[k+1].rem = wbpe_pkg::CNT_W'(two - {1'b0, st_ff[k].n});
         end else begin
            st_in[k+1].rem = two[wbpe_pkg::CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NS; i++) st_ff[i] <= '0;
      end else if (advance) begin
         for (int i = 0; i <= NS; i++) st_ff[i] <= st_in[i];
      end
   end

   // ---------------- control point table, one bank per point index
   logic [PW-1:0]  mem [0:3][0:MAX_SEGMENTS-1];
   logic [3:0][PW-1:0] rd_ff;
   logic [8:0]     wext, rext;
   logic [SEGW-1:0] waddr, raddr;
   logic           m_valid_ff, m_empty_ff;
   logic [wbpe_pkg::T_W-1:0] m_t_ff;

   always_comb begin
      wext  = {5'b0, st_ff[NS].seg_w};
      rext  = {4'b0, st_ff[NS].rem};
      waddr = wext[SEGW-1:0];
      raddr = rext[SEGW-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance && st_ff[NS].valid && !st_ff[NS].is_eval && st_ff[NS].wr_en) begin
         mem[st_ff[NS].pt][waddr] <= st_ff[NS].pnt;
      end
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      always_ff @(posedge clock) begin
         if (advance) begin
            rd_ff[b] <= mem[b][raddr];
         end
      end
   end

   // ---------------- Bernstein weights
   logic        w1_valid_ff, w1_empty_ff;
   logic [16:0] w1_s_ff;
   logic [15:0] w1_t_ff;
   logic [33:0] w1_s2_ff;
   logic [31:0] w1_t2_ff;
   logic [3:0][PW-1:0] w1_pnt_ff;
   logic [16:0] s_in;

   logic        w2_valid_ff, w2_empty_ff;
   logic [48:0] w2_w0_ff, w2_a1_ff, w2_a2_ff, w2_w3_ff;
   logic [3:0][PW-1:0] w2_pnt_ff;

   logic        w3_valid_ff, w3_empty_ff;
   logic [3:0][48:0] w3_w_ff;
   logic [3:0][PW-1:0] w3_pnt_ff;

   logic        p_valid_ff, p_empty_ff;
   logic [2:0][3:0][63:0] p_prod_ff;

   logic        a_valid_ff, a_empty_ff;
   logic [2:0][63:0] a_acc_ff;

   logic [2:0][CW-1:0] res_in;
   logic [2:0][CW-1:0] res_ff;
   logic        out_valid_ff, out_empty_ff;

   assign s_in = 17'h10000 - {1'b0, m_t_ff};

   always_comb begin
      logic [63:0] rnd;
      for (int c = 0; c < 3; c++) begin
         rnd       = a_acc_ff[c] + 64'h0000_8000_0000_0000;
         res_in[c] = a_empty_ff ? '0 : (rnd[63:48] ^ 16'h8000);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_t_ff     <= st_ff[NS].t16;
         m_empty_ff <= st_ff[NS].empty;

         w1_empty_ff <= m_empty_ff;
         w1_s_ff     <= s_in;
         w1_t_ff     <= m_t_ff;
         w1_s2_ff    <= 34'(s_in) * 34'(s_in);
         w1_t2_ff    <= 32'(m_t_ff) * 32'(m_t_ff);
         w1_pnt_ff   <= rd_ff;

         w2_empty_ff <= w1_empty_ff;
         w2_w0_ff    <= 49'(51'(w1_s2_ff) * 51'(w1_s_ff));
         w2_a1_ff    <= 49'(50'(w1_s2_ff) * 50'(w1_t_ff));
         w2_a2_ff    <= 49'(49'(w1_t2_ff) * 49'(w1_s_ff));
         w2_w3_ff    <= 49'(48'(w1_t2_ff) * 48'(w1_t_ff));
         w2_pnt_ff   <= w1_pnt_ff;

         w3_empty_ff <= w2_empty_ff;
         w3_w_ff[0]  <= w2_w0_ff;
         w3_w_ff[1]  <= w2_a1_ff + {w2_a1_ff[47:0], 1'b0};
         w3_w_ff[2]  <= w2_a2_ff + {w2_a2_ff[47:0], 1'b0};
         w3_w_ff[3]  <= w2_w3_ff;
         w3_pnt_ff   <= w2_pnt_ff;

         // coordinates biased to unsigned so the sum fits 64 bits
         p_empty_ff <= w3_empty_ff;
         for (int c = 0; c < 3; c++) begin
            for (int j = 0; j < 4; j++) begin
               p_prod_ff[c][j] <= 64'(w3_pnt_ff[j][PW-1-CW*c -: CW] ^ 16'h8000)
                                  * 64'(w3_w_ff[j]);
            end
         end

         a_empty_ff <= p_empty_ff;
         for (int c = 0; c < 3; c++) begin
            a_acc_ff[c] <= p_prod_ff[c][0] + p_prod_ff[c][1]
                           + p_prod_ff[c][2] + p_prod_ff[c][3];
         end

         out_empty_ff <= a_empty_ff;
         res_ff       <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         w1_valid_ff  <= 1'b0;
         w2_valid_ff  <= 1'b0;
         w3_valid_ff  <= 1'b0;
         p_valid_ff   <= 1'b0;
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff   <= st_ff[NS].valid && st_ff[NS].is_eval;
         w1_valid_ff  <= m_valid_ff;
         w2_valid_ff  <= w1_valid_ff;
         w3_valid_ff  <= w2_valid_ff;
         p_valid_ff   <= w3_valid_ff;
         a_valid_ff   <= p_valid_ff;
         out_valid_ff <= a_valid_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_point_x    = res_ff[0];
   assign rsp_point_y    = res_ff[1];
   assign rsp_point_z    = res_ff[2];
   assign rsp_path_empty = out_empty_ff;

endmodule

/* design/wrapped_bezier_path_evaluator_top.sv */
// Piecewise cubic Bezier path evaluator. Write beats (mode 0) store one Q8.8 control
// point of a segment; evaluate beats (mode 1) wrap position_u into [0, n), n being
// segment_count capped at MAX_SEGMENTS, and return the Bernstein blend of that
// segment, rounded to nearest, one result per evaluate beat and none per write. The
// block takes one beat per cycle and returns one result per cycle while rsp_ready is
// high. With an idle pipeline an evaluate beat passes through the queue, one wrap stage
// per integer bit of u below its sign bit, the table read and six weight, blend and
// output stages before rsp_valid rises. While a result waits the whole back end holds,
// and the four-beat queue keeps taking beats until it fills. Control points read before
// they are written are undefined; an empty path returns zeros with rsp_path_empty set.
module wrapped_bezier_path_evaluator_top #(
   parameter int MAX_SEGMENTS    = 16,
   parameter int PARAM_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic [3:0]                          req_segment_index,
   input  logic [1:0]                          req_point_index,
   input  logic signed [wbpe_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [wbpe_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [wbpe_pkg::COORD_W-1:0] req_coord_z,
   input  logic signed [wbpe_pkg::U_W-1:0]     req_position_u,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [wbpe_pkg::COORD_W-1:0] rsp_point_x,
   output logic signed [wbpe_pkg::COORD_W-1:0] rsp_point_y,
   output logic signed [wbpe_pkg::COORD_W-1:0] rsp_point_z,
   output logic                                rsp_path_empty,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wbpe_pkg::CNT_W-1:0]          csr_data
);

   // segment count register, always ready
   logic [wbpe_pkg::CNT_W-1:0] segment_count_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         segment_count_ff <= '0;
      end else if (csr_valid) begin
         segment_count_ff <= csr_data;
      end
   end

   wbpe_pkg::cmd_type front_cmd, q_cmd;
   logic              q_valid, q_ready;

   // front: classify beat, clamp count, check write range
   wbpe_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
      .mode          (req_mode),
      .segment_index (req_segment_index),
      .point_index   (req_point_index),
      .coord_x       (req_coord_x),
      .coord_y       (req_coord_y),
      .coord_z       (req_coord_z),
      .position_u    (req_position_u),
      .segment_count (segment_count_ff),
      .cmd           (front_cmd)
   );

   wbpe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (front_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_cmd)
   );

   // back: wrap, table access, blend, output register
   wbpe_back #(
      .MAX_SEGMENTS    (MAX_SEGMENTS),
      .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (q_valid),
      .pop_ready      (q_ready),
      .pop_data       (q_cmd),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_point_z    (rsp_point_z),
      .rsp_path_empty (rsp_path_empty)
   );

endmodule

/* design/wbpe_checker.sv */
module wbpe_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [wbpe_pkg::COORD_W-1:0] rsp_point_x,
   input logic signed [wbpe_pkg::COORD_W-1:0] rsp_point_y,
   input logic signed [wbpe_pkg::COORD_W-1:0] rsp_point_z,
   input logic                                rsp_path_empty
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_point_x)
         && $stable(rsp_point_y) && $stable(rsp_point_z) && $stable(rsp_path_empty))
      else $error("result beat changed while stalled");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_path_empty |->
         rsp_point_x == '0 && rsp_point_y == '0 && rsp_point_z == '0)
      else $error("empty path result not zero");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind wrapped_bezier_path_evaluator_top wbpe_checker u_wbpe_checker (.*);

/* tb/sv/tb_wrapped_bezier_path_evaluator_top.sv */
`timescale 1ns / 1ps

module tb_wrapped_bezier_path_evaluator_top;

   localparam int SEGS      = 16;
   localparam int FRAC      = 16;
   localparam int SETTLE    = 48;    // twice the pipeline depth (40 - FRAC)
   localparam int STALL_MAX = 4000;  // cycles with no beat on any channel
   localparam logic [4:0] COUNTS [10] = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd17, 5'd3, 5'd8,
                                          5'd2, 5'd24, 5'd5};

   typedef struct {
      logic signed [wbpe_pkg::COORD_W-1:0] x;
      logic signed [wbpe_pkg::COORD_W-1:0] y;
      logic signed [wbpe_pkg::COORD_W-1:0] z;
      logic                                empty;
   } path_point_type;

   // Mirror of the segment table, the segment count and the results still owed.
   class path_scoreboard;
      logic [15:0]         ctrl_pts [SEGS*4][3];
      logic [4:0]          seg_count;
      path_point_type      owed [$];
      int                  errors;

      function new();
         seg_count = 0;
         errors    = 0;
         foreach (ctrl_pts[i, k]) ctrl_pts[i][k] = '0;
      endfunction

      function logic [15:0] blend(int base, int k, longint unsigned w [4]);
         longint unsigned acc;
         longint unsigned r;
         acc = 0;
         for (int p = 0; p < 4; p++)
            acc += longint'(ctrl_pts[base+p][k] ^ 16'h8000) * w[p];
         r = (acc + (64'd1 << 47)) >> 48;
         return r[15:0] ^ 16'h8000;
      endfunction

      function path_point_type eval_path(logic [31:0] u_bits);
         path_point_type  pt;
         longint          u;
         longint          period;
         longint          r;
         longint unsigned t16;
         longint unsigned s;
         longint unsigned w [4];
         int              n;
         int              seg;
         n = (seg_count > SEGS) ? SEGS : seg_count;
         pt.empty = 0;
         if (n == 0) begin
            pt.x = 0; pt.y = 0; pt.z = 0; pt.empty = 1;
            return pt;
         end
         u      = longint'($signed(u_bits));
         period = longint'(n) << FRAC;
         r      = u % period;
         if (r < 0) r += period;
         seg = int'(r >> FRAC);
         if (seg >= n) seg = n - 1;
         t16  = longint'(r) & ((64'd1 << FRAC) - 1);
         t16 &= 16'hFFFF;
         s    = 65536 - t16;
         w[0] = s * s * s;
         w[1] = 3 * s * s * t16;
         w[2] = 3 * s * t16 * t16;
         w[3] = t16 * t16 * t16;
         pt.x = blend(seg * 4, 0, w);
         pt.y = blend(seg * 4, 1, w);
         pt.z = blend(seg * 4, 2, w);
         return pt;
      endfunction

      function void note_beat(logic mode, logic [3:0] seg, logic [1:0] pidx,
                              logic [15:0] x, logic [15:0] y, logic [15:0] z,
                              logic [31:0] u);
         if (mode == 1'b0) begin
            ctrl_pts[seg*4+pidx][0] = x;
            ctrl_pts[seg*4+pidx][1] = y;
            ctrl_pts[seg*4+pidx][2] = z;
         end else begin
            owed = {owed, eval_path(u)};
         end
      endfunction

      function void check_rsp(path_point_type got);
         path_point_type want;
         if (owed.size() == 0) begin
            $error("result beat with nothing owed");
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.x !== want.x) begin
            $error("point_x expected %0d got %0d", want.x, got.x); errors++;
         end
         if (got.y !== want.y) begin
            $error("point_y expected %0d got %0d", want.y, got.y); errors++;
         end
         if (got.z !== want.z) begin
            $error("point_z expected %0d got %0d", want.z, got.z); errors++;
         end
         if (got.empty !== want.empty) begin
            $error("path_empty expected %0d got %0d", want.empty, got.empty); errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_mode = 0;
   logic [3:0]  req_segment_index = 0;
   logic [1:0]  req_point_index = 0;
   logic signed [15:0] req_coord_x = 0;
   logic signed [15:0] req_coord_y = 0;
   logic signed [15:0] req_coord_z = 0;
   logic signed [31:0] req_position_u = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic signed [15:0] rsp_point_x;
   logic signed [15:0] rsp_point_y;
   logic signed [15:0] rsp_point_z;
   logic        rsp_path_empty;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [4:0]  csr_data = 0;

   path_scoreboard sb = new();
   bit          calm = 0;        // no idling on either side while set
   logic [15:0] loaded;          // segments whose four points have been written
   int          quiet_cycles = 0;

   wrapped_bezier_path_evaluator_top #(
      .MAX_SEGMENTS   (SEGS),
      .PARAM_FRAC_BITS(FRAC)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_segment_index(req_segment_index),
      .req_point_index  (req_point_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_coord_z      (req_coord_z),
      .req_position_u   (req_position_u),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y),
      .rsp_point_z      (rsp_point_z),
      .rsp_path_empty   (rsp_path_empty),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Receiver: stall about 15% of cycles, except during the calm stretch.
   always @(posedge clock) begin
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
   end

   // Monitor: every beat is seen on the edge at which it is accepted, with values
   // from before that edge's updates, so the order of events does not matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_beat(req_mode, req_segment_index, req_point_index,
                         req_coord_x, req_coord_y, req_coord_z, req_position_u);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_rsp('{rsp_point_x, rsp_point_y, rsp_point_z, rsp_path_empty});
         end
         if (csr_valid && csr_ready) begin
            sb.seg_count = csr_data;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)
             || (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Watchdog: a run that stops making progress fails.
   initial begin
      wait (quiet_cycles >= STALL_MAX);
      $display("Simulation FAILED");
      $finish;
   end

   // Holds one request beat until it is accepted. The next beat, or an idle, is
   // then driven on that same edge, so valid gets one assignment per edge.
   task automatic send_beat(logic mode, logic [3:0] seg, logic [1:0] pidx,
                            logic [15:0] x, logic [15:0] y, logic [15:0] z,
                            logic [31:0] u);
      while (!calm && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_segment_index <= seg;
      req_point_index   <= pidx;
      req_coord_x       <= x;
      req_coord_y       <= y;
      req_coord_z       <= z;
      req_position_u    <= u;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic stop_req();
      req_valid <= 1'b0;
   endtask

   task automatic write_point(logic [3:0] seg, logic [1:0] pidx,
                              logic [15:0] x, logic [15:0] y, logic [15:0] z);
      send_beat(1'b0, seg, pidx, x, y, z, $urandom());
   endtask

   task automatic evaluate(logic [31:0] u);
      send_beat(1'b1, 4'($urandom()), 2'($urandom()), 16'($urandom()), 16'($urandom()),
                16'($urandom()), u);
   endtask

   // Wait until every owed result is back, then let the pipeline empty out.
   task automatic drain();
      stop_req();
      @(posedge clock);
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_count(logic [4:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         default: return 16'($urandom());
      endcase
   endfunction

   // u near a segment boundary, fully random, or with a small integer part of either sign.
   function automatic logic [31:0] pick_u();
      int seg;
      seg = $urandom_range(63) - 32;
      case ($urandom_range(5))
         0:       return {seg[15:0], 16'h0000};
         1:       return {seg[15:0], 16'hFFFF};
         2:       return $urandom();
         default: return {seg[15:0], 16'(($urandom()))};
      endcase
   endfunction

   // Load any segment in use whose points have not all been written yet.
   task automatic load_segments(int n);
      for (int s = 0; s < n && s < SEGS; s++) begin
         if (!loaded[s]) begin
            for (int p = 0; p < 4; p++)
               write_point(4'(s), 2'(p), pick_coord(), pick_coord(), pick_coord());
            loaded[s] = 1'b1;
         end
      end
   endtask

   initial begin
      loaded = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty path first, then one segment at the coordinate extremes.
      evaluate(32'h0000_0000);
      evaluate(32'h8000_0000);
      write_point(0, 0, 16'h8000, 16'h7FFF, 16'h0000);
      write_point(0, 1, 16'h7FFF, 16'h8000, 16'h7FFF);
      write_point(0, 2, 16'h8000, 16'h7FFF, 16'h8000);
      write_point(0, 3, 16'h7FFF, 16'h8000, 16'hFFFF);
      loaded[0] = 1'b1;
      drain();
      set_count(5'd1);
      evaluate(32'h0000_0000);   // t = 0 gives p0
      evaluate(32'h0000_FFFF);   // t just below one
      evaluate(32'h0000_8000);   // midpoint
      evaluate(32'hFFFF_FFFF);   // negative u wraps into the segment
      evaluate(32'h7FFF_FFFF);
      evaluate(32'h8000_0000);
      evaluate(32'h0001_0000);   // exactly one period
      drain();

      // Random phases. Each count change waits for the block to go idle.
      for (int ph = 0; ph < 10; ph++) begin
         int n;
         set_count(COUNTS[ph]);
         n = (COUNTS[ph] > SEGS) ? SEGS : int'(COUNTS[ph]);
         load_segments(n);
         calm = (ph == 2);
         for (int i = 0; i < 68; i++) begin
            if ($urandom_range(99) < 25) begin
               write_point(4'($urandom()), 2'($urandom()), pick_coord(), pick_coord(),
                           pick_coord());
            end else begin
               evaluate(pick_u());
            end
            // A write may land on a segment not fully loaded; re-fill before use.
            if (req_mode == 1'b0 && !loaded[req_segment_index]) begin
               load_segments(n);
            end
         end
         calm = 0;
         drain();
      end

      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/wbpe_pkg.sv
design/wbpe_queue.sv
design/wbpe_front.sv
design/wbpe_back.sv
design/wrapped_bezier_path_evaluator_top.sv
design/wbpe_checker.sv
tb/sv/tb_wrapped_bezier_path_evaluator_top.sv
